// ===== rtl/bdp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdp_pkg
// Shared types and constants of the delayed-update branch direction predictor.
// ----------------------------------------------------------------------------
package bdp_pkg;

    localparam int APB_AW = 5;
    localparam int APB_DW = 32;

    // register indexes (paddr[4:2])
    localparam logic [2:0] REG_KIND    = 3'd0;
    localparam logic [2:0] REG_IWIDTH  = 3'd1;
    localparam logic [2:0] REG_HLEN    = 3'd2;
    localparam logic [2:0] REG_DELAY   = 3'd3;
    localparam logic [2:0] REG_FOLD    = 3'd4;

    // predictor kinds
    localparam logic [1:0] KIND_BIMODAL = 2'd0;
    localparam logic [1:0] KIND_GSHARE  = 2'd1;

    localparam logic [1:0] KIND_RESET   = 2'd1;
    localparam logic [3:0] IWIDTH_RESET = 4'd8;
    localparam logic [3:0] HLEN_RESET   = 4'd8;
    localparam logic [3:0] DELAY_RESET  = 4'd0;
    localparam logic       FOLD_RESET   = 1'b0;

    // weakly not-taken
    localparam logic [1:0] CNT_RESET    = 2'b01;

    typedef struct packed {
        logic [1:0] predictor_kind;
        logic [3:0] index_width;
        logic [3:0] history_length;
        logic [3:0] update_delay;
        logic       fold_address;
    } cfg_t;

    typedef struct packed {
        logic clear_en;
        logic capture;
        logic retire;
        logic push;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic head_due;
        logic queue_full;
        logic out_free;
        logic delay_zero;
    } dp_status_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_IDX,
        ST_MUL1,
        ST_MUL2,
        ST_MOD,
        ST_DRAIN_RD,
        ST_DRAIN_CHK,
        ST_LOOK,
        ST_PUSH,
        ST_POST_RD,
        ST_POST_CHK
    } state_t;

endpackage

// ===== rtl/bdp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdp_if
// Valid/ready channels: branch items in, predictions out.
// ----------------------------------------------------------------------------
interface bdp_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] branch_cycle;
    logic [31:0] branch_address;
    logic        outcome_taken;
    logic [7:0]  recorded_index;

    modport source (
        output valid, branch_cycle, branch_address, outcome_taken, recorded_index,
        input  ready
    );
    modport sink (
        input  valid, branch_cycle, branch_address, outcome_taken, recorded_index,
        output ready
    );
endinterface

interface bdp_out_if;
    logic valid;
    logic ready;
    logic predict_taken;

    modport source (
        output valid, predict_taken,
        input  ready
    );
    modport sink (
        input  valid, predict_taken,
        output ready
    );
endinterface

// ===== rtl/branch_direction_predictor_delayed.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// branch_direction_predictor_delayed
// Bimodal / gshare / gselect 2-bit predictor with delayed counter training.
// ----------------------------------------------------------------------------
// One branch item in, one prediction item out. After reset the counter table
// is swept to weakly not-taken, one entry a cycle; items are not accepted
// during that pass (configuration writes are). Each item then goes through
// capture, the four-stage index and modulo pipeline, a queue head check, the
// table read and the push, which waits for a free output register. Each due
// queued update retires before the lookup with its own head read and check,
// and after the push too when update_delay is 0. The cost is set by the counter
// table's single write port and the one-entry-per-visit head read. A finished
// prediction waits in an output register while the next item is accepted.
module branch_direction_predictor_delayed #(
    parameter int MAX_ENTRIES = 512,
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [bdp_pkg::APB_AW-1:0] paddr,
    input  logic [bdp_pkg::APB_DW-1:0] pwdata,
    output logic [bdp_pkg::APB_DW-1:0] prdata,
    output logic                       pready,
    bdp_in_if.sink                     in_ch,
    bdp_out_if.source                  out_ch
);

    bdp_pkg::cfg_t       cfg;
    bdp_pkg::dp_cmd_t    cmd;
    bdp_pkg::dp_status_t status;
    logic                in_ready;

    assign in_ch.ready = in_ready;

    bdp_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bdp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    bdp_dpath #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .cmd            (cmd),
        .status         (status),
        .branch_cycle   (in_ch.branch_cycle),
        .branch_address (in_ch.branch_address),
        .outcome_taken  (in_ch.outcome_taken),
        .recorded_index (in_ch.recorded_index),
        .out_valid      (out_ch.valid),
        .out_ready      (out_ch.ready),
        .predict_taken  (out_ch.predict_taken)
    );

endmodule

// ===== rtl/bdp_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdp_regs
// APB configuration registers.
// ----------------------------------------------------------------------------
module bdp_regs (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [bdp_pkg::APB_AW-1:0] paddr,
    input  logic [bdp_pkg::APB_DW-1:0] pwdata,
    output logic [bdp_pkg::APB_DW-1:0] prdata,
    output logic                       pready,
    output bdp_pkg::cfg_t              cfg
);

    bdp_pkg::cfg_t cfg_reg;
    bdp_pkg::cfg_t cfg_next;
    logic [2:0]    reg_sel;
    logic          wr_en;

    assign reg_sel = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_sel)
                bdp_pkg::REG_KIND:   cfg_next.predictor_kind = pwdata[1:0];
                bdp_pkg::REG_IWIDTH: cfg_next.index_width    = pwdata[3:0];
                bdp_pkg::REG_HLEN:   cfg_next.history_length = pwdata[3:0];
                bdp_pkg::REG_DELAY:  cfg_next.update_delay   = pwdata[3:0];
                bdp_pkg::REG_FOLD:   cfg_next.fold_address   = pwdata[0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.predictor_kind <= bdp_pkg::KIND_RESET;
            cfg_reg.index_width    <= bdp_pkg::IWIDTH_RESET;
            cfg_reg.history_length <= bdp_pkg::HLEN_RESET;
            cfg_reg.update_delay   <= bdp_pkg::DELAY_RESET;
            cfg_reg.fold_address   <= bdp_pkg::FOLD_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        case (reg_sel)
            bdp_pkg::REG_KIND:   prdata = {30'd0, cfg_reg.predictor_kind};
            bdp_pkg::REG_IWIDTH: prdata = {28'd0, cfg_reg.index_width};
            bdp_pkg::REG_HLEN:   prdata = {28'd0, cfg_reg.history_length};
            bdp_pkg::REG_DELAY:  prdata = {28'd0, cfg_reg.update_delay};
            bdp_pkg::REG_FOLD:   prdata = {31'd0, cfg_reg.fold_address};
            default:             prdata = '0;
        endcase
    end

endmodule

// ===== rtl/bdp_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdp_ctrl
// Sequencer: table clear, index pipeline, drain, lookup, push, post-drain.
// ----------------------------------------------------------------------------
module bdp_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  bdp_pkg::dp_status_t status,
    output bdp_pkg::dp_cmd_t    cmd
);

    bdp_pkg::state_t state_reg;
    bdp_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bdp_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bdp_pkg::ST_CLEAR:
                if (status.clear_done)
                    state_next = bdp_pkg::ST_IDLE;
            bdp_pkg::ST_IDLE:
                if (in_valid)
                    state_next = bdp_pkg::ST_IDX;
            bdp_pkg::ST_IDX:      state_next = bdp_pkg::ST_MUL1;
            bdp_pkg::ST_MUL1:     state_next = bdp_pkg::ST_MUL2;
            bdp_pkg::ST_MUL2:     state_next = bdp_pkg::ST_MOD;
            bdp_pkg::ST_MOD:      state_next = bdp_pkg::ST_DRAIN_RD;
            bdp_pkg::ST_DRAIN_RD: state_next = bdp_pkg::ST_DRAIN_CHK;
            bdp_pkg::ST_DRAIN_CHK:
                state_next = status.head_due ? bdp_pkg::ST_DRAIN_RD : bdp_pkg::ST_LOOK;
            bdp_pkg::ST_LOOK:     state_next = bdp_pkg::ST_PUSH;
            bdp_pkg::ST_PUSH:
                if (status.out_free)
                    state_next = status.delay_zero ? bdp_pkg::ST_POST_RD : bdp_pkg::ST_IDLE;
            bdp_pkg::ST_POST_RD:  state_next = bdp_pkg::ST_POST_CHK;
            bdp_pkg::ST_POST_CHK:
                state_next = status.head_due ? bdp_pkg::ST_POST_RD : bdp_pkg::ST_IDLE;
            default:              state_next = bdp_pkg::ST_CLEAR;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            bdp_pkg::ST_CLEAR:
                cmd.clear_en = 1'b1;
            bdp_pkg::ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            bdp_pkg::ST_DRAIN_CHK,
            bdp_pkg::ST_POST_CHK:
                cmd.retire = status.head_due;
            bdp_pkg::ST_PUSH:
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    cmd.push     = 1'b1;
                    cmd.retire   = status.queue_full;
                end
            default:
                cmd = '0;
        endcase
    end

endmodule

// ===== rtl/bdp_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdp_dpath
// Index formation, counter table, pending-update queue and output register.
// ----------------------------------------------------------------------------
module bdp_dpath #(
    parameter int MAX_ENTRIES = 512,
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  bdp_pkg::cfg_t       cfg,
    input  bdp_pkg::dp_cmd_t    cmd,
    output bdp_pkg::dp_status_t status,
    input  logic [31:0]         branch_cycle,
    input  logic [31:0]         branch_address,
    input  logic                outcome_taken,
    input  logic [7:0]          recorded_index,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                predict_taken
);

    localparam int AW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int QW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW    = $clog2(QUEUE_DEPTH + 1);
    localparam int RECIP = 4096 / MAX_ENTRIES;

    localparam logic [12:0]   ENTRIES_W = 13'(MAX_ENTRIES);
    localparam logic [12:0]   RECIP_W   = 13'(RECIP);
    localparam logic [AW-1:0] LAST_ENT  = AW'(MAX_ENTRIES - 1);
    localparam logic [QW-1:0] LAST_SLOT = QW'(QUEUE_DEPTH - 1);
    localparam logic [CW:0]   DEPTH_S   = (CW + 1)'(QUEUE_DEPTH);
    localparam logic [CW-1:0] DEPTH_C   = CW'(QUEUE_DEPTH);

    function automatic logic [11:0] mask12(input logic [3:0] w);
        logic [12:0] t;
        t = (13'd1 << w) - 13'd1;
        return t[11:0];
    endfunction

    function automatic logic [11:0] fold30(input logic [29:0] v, input logic [3:0] w);
        logic [11:0] acc;
        logic [3:0]  pos;
        acc = '0;
        for (int wi = 1; wi <= 12; wi++)
        begin
            if (w == 4'(wi))
            begin
                pos = '0;
                for (int k = 0; k < 30; k++)
                begin
                    acc[pos] = acc[pos] ^ v[k];
                    pos = (pos == 4'(wi - 1)) ? 4'd0 : pos + 4'd1;
                end
            end
        end
        return acc;
    endfunction

    function automatic logic [11:0] fold8(input logic [7:0] v, input logic [3:0] w);
        logic [11:0] acc;
        logic [3:0]  pos;
        acc = '0;
        for (int wi = 1; wi <= 12; wi++)
        begin
            if (w == 4'(wi))
            begin
                pos = '0;
                for (int k = 0; k < 8; k++)
                begin
                    acc[pos] = acc[pos] ^ v[k];
                    pos = (pos == 4'(wi - 1)) ? 4'd0 : pos + 4'd1;
                end
            end
        end
        return acc;
    endfunction

    // captured item
    logic [31:0] cycle_reg;
    logic [31:0] pc_reg;
    logic        taken_reg;
    logic [7:0]  ridx_reg;

    // index pipeline
    logic [11:0]   raw_reg;
    logic [11:0]   q_reg;
    logic [11:0]   qm_reg;
    logic [AW-1:0] ix_reg;

    // counter table
    logic [1:0]    cnt_mem [MAX_ENTRIES];
    logic [1:0]    cnt_rd_reg;
    logic [AW-1:0] clr_reg;
    logic [AW-1:0] clr_next;

    // pending-update queue
    logic [32:0]   due_mem  [QUEUE_DEPTH];
    logic [AW-1:0] qidx_mem [QUEUE_DEPTH];
    logic [1:0]    snap_mem [QUEUE_DEPTH];
    logic          tk_mem   [QUEUE_DEPTH];
    logic [32:0]   hd_due_reg;
    logic [AW-1:0] hd_idx_reg;
    logic [1:0]    hd_snap_reg;
    logic          hd_tk_reg;
    logic [QW-1:0] head_reg;
    logic [QW-1:0] head_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [QW-1:0] tail;
    logic [CW:0]   tail_sum;

    // output
    logic out_valid_reg;
    logic out_valid_next;
    logic pred_reg;

    // index formation
    logic [3:0]  iw;
    logic [3:0]  hl8;
    logic [3:0]  hin;
    logic [3:0]  pbits;
    logic [29:0] word;
    logic [11:0] pcix;
    logic [7:0]  ghr;
    logic [7:0]  ghr_m;
    logic [11:0] gsel;
    logic [11:0] raw_idx;
    logic [25:0] prod1;
    logic [25:0] prod2;
    logic [11:0] rem;
    logic [12:0] rem_sub;
    logic [1:0]  upd_cnt;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cycle_reg <= branch_cycle;
            pc_reg    <= branch_address;
            taken_reg <= outcome_taken;
            ridx_reg  <= recorded_index;
        end
    end

    always_comb
    begin
        iw    = (cfg.index_width > 4'd12) ? 4'd12 : cfg.index_width;
        word  = pc_reg[31:2];
        pcix  = cfg.fold_address ? fold30(word, iw) : (word[11:0] & mask12(iw));
        ghr   = ridx_reg ^ pc_reg[9:2];
        hl8   = (cfg.history_length > 4'd8) ? 4'd8 : cfg.history_length;
        ghr_m = ghr & 8'(mask12(hl8));
        hin   = (cfg.history_length < iw) ? cfg.history_length : iw;
        pbits = iw - hin;
        gsel  = ((pcix & mask12(pbits)) << hin) | ({4'd0, ghr} & mask12(hin));
        case (cfg.predictor_kind)
            bdp_pkg::KIND_BIMODAL: raw_idx = pcix;
            bdp_pkg::KIND_GSHARE:  raw_idx = pcix ^ fold8(ghr_m, iw);
            default:               raw_idx = gsel;
        endcase
    end

    // raw index modulo table size: reciprocal estimate, one correction
    assign prod1   = {1'b0, raw_reg, 13'd0} >> 13 == '0 ? '0 : {1'b0, raw_reg} * RECIP_W;
    assign prod2   = {1'b0, q_reg} * ENTRIES_W;
    assign rem     = raw_reg - qm_reg;
    assign rem_sub = {1'b0, rem} - ENTRIES_W;

    always_ff @(posedge clk)
    begin
        raw_reg <= raw_idx;
        q_reg   <= prod1[23:12];
        qm_reg  <= prod2[11:0];
        ix_reg  <= ({1'b0, rem} >= ENTRIES_W) ? rem_sub[AW-1:0] : AW'(rem);
    end

    // counter table
    always_comb
    begin
        if (hd_tk_reg)
            upd_cnt = (hd_snap_reg == 2'b11) ? 2'b11 : hd_snap_reg + 2'b01;
        else
            upd_cnt = (hd_snap_reg == 2'b00) ? 2'b00 : hd_snap_reg - 2'b01;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clear_en)
            cnt_mem[clr_reg] <= bdp_pkg::CNT_RESET;
        else if (cmd.retire)
            cnt_mem[hd_idx_reg] <= upd_cnt;
        cnt_rd_reg <= cnt_mem[ix_reg];
    end

    assign clr_next = (cmd.clear_en && clr_reg != LAST_ENT) ? clr_reg + AW'(1) : clr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_reg <= '0;
        else
            clr_reg <= clr_next;
    end

    // queue
    assign tail_sum = {1'b0, CW'(head_reg)} + {1'b0, count_reg};

    always_comb
    begin
        if (count_reg == DEPTH_C)
            tail = head_reg;
        else if (tail_sum >= DEPTH_S)
            tail = QW'(tail_sum - DEPTH_S);
        else
            tail = QW'(tail_sum);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            due_mem[tail]  <= {1'b0, cycle_reg} + {29'd0, cfg.update_delay};
            qidx_mem[tail] <= ix_reg;
            snap_mem[tail] <= cnt_rd_reg;
            tk_mem[tail]   <= taken_reg;
        end
        hd_due_reg  <= due_mem[head_reg];
        hd_idx_reg  <= qidx_mem[head_reg];
        hd_snap_reg <= snap_mem[head_reg];
        hd_tk_reg   <= tk_mem[head_reg];
    end

    always_comb
    begin
        head_next = head_reg;
        if (cmd.retire)
            head_next = (head_reg == LAST_SLOT) ? '0 : head_reg + QW'(1);
        count_next = count_reg + CW'(cmd.push) - CW'(cmd.retire);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    // output register
    assign out_valid_next = cmd.load_out ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
            pred_reg <= cnt_rd_reg[1];
    end

    assign out_valid     = out_valid_reg;
    assign predict_taken = pred_reg;

    assign status.clear_done = (clr_reg == LAST_ENT);
    assign status.head_due   = (count_reg != '0) && (hd_due_reg <= {1'b0, cycle_reg});
    assign status.queue_full = (count_reg == DEPTH_C);
    assign status.out_free   = !out_valid_reg || out_ready;
    assign status.delay_zero = (cfg.update_delay == 4'd0);

endmodule

// ===== tb/branch_direction_predictor_delayed_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// branch_direction_predictor_delayed_test
// Self-checking bench for the delayed-training branch direction predictor.
// ----------------------------------------------------------------------------
// Keeps a shadow pattern table, training queue and register copy in the bench.
// Each branch accepted on the input channel is looked up in that shadow to
// get the expected direction. Each prediction item is compared in order.
// Directed items cover field extremes, every index mode, the queue overflow
// and cycle wrap. Random phases then run with changing settings, idling and
// output stalls.
// ----------------------------------------------------------------------------
module branch_direction_predictor_delayed_test;

    localparam int TABLE_SIZE    = 512;
    localparam int TRAIN_DEPTH   = 16;
    localparam int SETTLE_CYCLES = 100;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_ITEMS   = 162;

    localparam logic [1:0] KIND_GSELECT = 2'd2;
    localparam logic [1:0] KIND_UNUSED  = 2'd3;

    typedef struct {
        longint unsigned due;
        logic [8:0]      slot;
        logic [1:0]      snap;
        bit              taken;
    } train_t;

    logic                        clk;
    logic                        rst_n;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [bdp_pkg::APB_AW-1:0]  paddr;
    logic [bdp_pkg::APB_DW-1:0]  pwdata;
    logic [bdp_pkg::APB_DW-1:0]  prdata;
    logic                        pready;

    bdp_in_if  in_ch ();
    bdp_out_if out_ch ();

    branch_direction_predictor_delayed dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_ch),
        .out_ch  (out_ch)
    );

    bdp_pkg::cfg_t shadow_cfg;
    logic [1:0]    pht [TABLE_SIZE];
    train_t        train_queue [$];
    bit            expected_dirs [$];

    int idle_pct     = 0;
    int stall_pct    = 0;
    int n_items      = 0;
    int n_checked    = 0;
    int n_errors     = 0;
    int n_reg_writes = 0;

    always #5 clk = ~clk;

    always @(posedge clk)
        out_ch.ready <= ($urandom_range(99) >= stall_pct);

    // ---------------- shadow predictor ----------------

    function automatic logic [63:0] low_bits(int w);
        return (w == 0) ? 64'd0 : ((64'd1 << w) - 64'd1);
    endfunction

    function automatic logic [31:0] fold_bits(logic [63:0] v, int vbits, int obits);
        logic [63:0] acc;
        logic [63:0] m;
        if (obits == 0)
            return 32'd0;
        m   = low_bits(obits);
        v   = v & low_bits(vbits);
        acc = 64'd0;
        for (int off = 0; off < vbits; off += obits)
            acc ^= (v >> off) & m;
        return acc[31:0];
    endfunction

    function automatic logic [8:0] table_slot(logic [31:0] pc, logic [7:0] ridx);
        int          iw;
        int          hlen;
        int          hin;
        logic [63:0] word;
        logic [63:0] ghr;
        logic [31:0] pcix;
        logic [31:0] r;
        iw   = (shadow_cfg.index_width > 4'd12) ? 12 : int'(shadow_cfg.index_width);
        hlen = int'(shadow_cfg.history_length);
        word = {34'd0, pc[31:2]};
        ghr  = {56'd0, ridx ^ pc[9:2]};
        if (shadow_cfg.fold_address)
            pcix = fold_bits(word, 30, iw);
        else
            pcix = 32'(word & low_bits(iw));
        case (shadow_cfg.predictor_kind)
            bdp_pkg::KIND_BIMODAL: r = pcix;
            bdp_pkg::KIND_GSHARE:  r = pcix ^ fold_bits(ghr, hlen, iw);
            default:
            begin
                hin = (hlen < iw) ? hlen : iw;
                r   = ((pcix & 32'(low_bits(iw - hin))) << hin) | 32'(ghr & low_bits(hin));
            end
        endcase
        return 9'(r % TABLE_SIZE);
    endfunction

    function automatic void retire_oldest();
        train_t     e;
        logic [1:0] c;
        e = train_queue[0];
        train_queue.delete(0);
        c = e.snap;
        if (e.taken)
            c = (c == 2'd3) ? 2'd3 : c + 2'd1;
        else
            c = (c == 2'd0) ? 2'd0 : c - 2'd1;
        pht[e.slot] = c;
    endfunction

    function automatic void retire_due(logic [31:0] cyc);
        while (train_queue.size() > 0 && train_queue[0].due <= {32'd0, cyc})
            retire_oldest();
    endfunction

    function automatic bit predict_direction(logic [31:0] cyc, logic [31:0] pc,
                                             bit taken, logic [7:0] ridx);
        train_t e;
        retire_due(cyc);
        e.slot  = table_slot(pc, ridx);
        e.snap  = pht[e.slot];
        e.taken = taken;
        e.due   = {32'd0, cyc} + 64'(shadow_cfg.update_delay);
        if (train_queue.size() >= TRAIN_DEPTH)
            retire_oldest();
        train_queue.insert(train_queue.size(), e);
        if (shadow_cfg.update_delay == 4'd0)
            retire_due(cyc);
        return e.snap[1];
    endfunction

    // ---------------- result checking ----------------

    task automatic report_mismatch(string what, bit want, bit got);
        n_errors++;
        if (n_errors <= 10)
            $display("MISMATCH %s at %0t: expected predict_taken=%0b, got %0b",
                     what, $realtime, want, got);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            n_checked++;
            if (expected_dirs.size() == 0)
                report_mismatch("unexpected item", 1'b0, out_ch.predict_taken);
            else if (expected_dirs[0] != out_ch.predict_taken)
                report_mismatch("prediction", expected_dirs[0], out_ch.predict_taken);
            if (expected_dirs.size() != 0)
                expected_dirs.delete(0);
        end
    end

    // ---------------- drivers ----------------

    task automatic send_branch(logic [31:0] cyc, logic [31:0] pc, bit taken,
                               logic [7:0] ridx);
        while ($urandom_range(99) < idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.branch_cycle   <= cyc;
        in_ch.branch_address <= pc;
        in_ch.outcome_taken  <= taken;
        in_ch.recorded_index <= ridx;
        do
            @(posedge clk);
        while (!in_ch.ready);
        expected_dirs.insert(expected_dirs.size(), predict_direction(cyc, pc, taken, ridx));
        n_items++;
    endtask

    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (expected_dirs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        case (idx)
            bdp_pkg::REG_KIND:   shadow_cfg.predictor_kind = value[1:0];
            bdp_pkg::REG_IWIDTH: shadow_cfg.index_width    = value[3:0];
            bdp_pkg::REG_HLEN:   shadow_cfg.history_length = value[3:0];
            bdp_pkg::REG_DELAY:  shadow_cfg.update_delay   = value[3:0];
            bdp_pkg::REG_FOLD:   shadow_cfg.fold_address   = value[0];
            default: ;
        endcase
        n_reg_writes++;
    endtask

    task automatic apply_settings(logic [1:0] kind, int iw, int hl, int delay, bit fold);
        wait_idle();
        write_reg(bdp_pkg::REG_KIND,   32'(kind));
        write_reg(bdp_pkg::REG_IWIDTH, 32'(iw));
        write_reg(bdp_pkg::REG_HLEN,   32'(hl));
        write_reg(bdp_pkg::REG_DELAY,  32'(delay));
        write_reg(bdp_pkg::REG_FOLD,   32'(fold));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // ---------------- tests ----------------

    task automatic test_reset_defaults();
        send_branch(32'd0, 32'h0000_0000, 1'b1, 8'h00);
        send_branch(32'd1, 32'hFFFF_FFFF, 1'b0, 8'hFF);
        send_branch(32'd1, 32'h0000_0000, 1'b1, 8'h00);
    endtask

    task automatic test_index_modes();
        apply_settings(bdp_pkg::KIND_BIMODAL, 9, 8, 0, 1'b1);
        send_branch(32'd10, 32'hDEAD_BEEF, 1'b1, 8'h5A);
        // zero index width
        apply_settings(KIND_GSELECT, 0, 4, 0, 1'b0);
        send_branch(32'd11, 32'h8000_0000, 1'b0, 8'hFF);
        // reserved kind, clamped width, history past 8 bits
        apply_settings(KIND_UNUSED, 15, 15, 0, 1'b1);
        send_branch(32'd12, 32'h7FFF_FFFC, 1'b1, 8'h00);
        apply_settings(bdp_pkg::KIND_GSHARE, 12, 0, 0, 1'b1);
        send_branch(32'd13, 32'hFFFF_FFFF, 1'b1, 8'hA5);
    endtask

    task automatic test_queue_overflow();
        apply_settings(bdp_pkg::KIND_BIMODAL, 4, 0, 15, 1'b0);
        // same cycle: nothing comes due, so the full queue retires early
        for (int i = 0; i < TRAIN_DEPTH + 1; i++)
            send_branch(32'hFFFF_FFF0, 32'h0000_1004, 1'b1, 8'(i));
        // due stamp runs past 32 bits, then the cycle goes backwards
        send_branch(32'hFFFF_FFFF, 32'h0000_1004, 1'b0, 8'h3C);
        send_branch(32'd3, 32'h0000_1004, 1'b1, 8'hC3);
    endtask

    task automatic test_random_traffic();
        logic [31:0] pool_pc [8];
        int          pool_bias [8];
        logic [31:0] now_cycle;
        logic [31:0] pc;
        logic [7:0]  ghist;
        int          step_max;
        int          k;
        int          delay;
        int          iw;
        int          hl;
        bit          taken;
        now_cycle = $urandom();
        ghist     = 8'd0;
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p % 3)
                0:       delay = 0;
                1:       delay = 15;
                default: delay = $urandom_range(1, 14);
            endcase
            iw = ($urandom_range(4) == 0) ? $urandom_range(15) : $urandom_range(3, 9);
            hl = ($urandom_range(3) == 0) ? $urandom_range(9, 15) : $urandom_range(8);
            apply_settings(2'(p % 4), iw, hl, delay, 1'($urandom_range(1)));
            case (p % 4)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 59; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 59; end
                default: begin idle_pct = 23; stall_pct = 23; end
            endcase
            for (int j = 0; j < 8; j++)
            begin
                pool_pc[j] = $urandom();
                case ($urandom_range(2))
                    0:       pool_bias[j] = 5;
                    1:       pool_bias[j] = 50;
                    default: pool_bias[j] = 95;
                endcase
            end
            // every third phase is a burst of closely spaced branch cycles
            step_max = (p % 3 == 2) ? 1 : $urandom_range(2, 12);
            repeat (PHASE_ITEMS)
            begin
                if ($urandom_range(99) < 12)
                begin
                    send_branch($urandom(), $urandom(), 1'($urandom_range(1)), 8'($urandom()));
                end
                else
                begin
                    k         = $urandom_range(7);
                    pc        = pool_pc[k];
                    taken     = ($urandom_range(99) < pool_bias[k]);
                    now_cycle = now_cycle + 32'($urandom_range(step_max));
                    send_branch(now_cycle, pc, taken, ghist ^ pc[9:2]);
                    ghist = {ghist[6:0], taken};
                end
            end
        end
        idle_pct  = 0;
        stall_pct = 0;
    endtask

    // ---------------- sequence ----------------

    initial
    begin
        clk                  = 1'b0;
        rst_n                = 1'b0;
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = '0;
        pwdata               = '0;
        in_ch.valid          = 1'b0;
        in_ch.branch_cycle   = '0;
        in_ch.branch_address = '0;
        in_ch.outcome_taken  = 1'b0;
        in_ch.recorded_index = '0;
        out_ch.ready         = 1'b0;
        shadow_cfg.predictor_kind = bdp_pkg::KIND_RESET;
        shadow_cfg.index_width    = bdp_pkg::IWIDTH_RESET;
        shadow_cfg.history_length = bdp_pkg::HLEN_RESET;
        shadow_cfg.update_delay   = bdp_pkg::DELAY_RESET;
        shadow_cfg.fold_address   = bdp_pkg::FOLD_RESET;
        for (int i = 0; i < TABLE_SIZE; i++)
            pht[i] = bdp_pkg::CNT_RESET;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_index_modes();
        test_queue_overflow();
        test_random_traffic();

        wait_idle();
        $display("Run covered %0d branch items and %0d predictions checked.",
                 n_items, n_checked);
        $display("Settings changed through %0d register writes; %0d mismatches.",
                 n_reg_writes, n_errors);
        if (n_errors == 0 && expected_dirs.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("Timeout with %0d predictions outstanding", expected_dirs.size());
        $display("Some tests failed");
        $finish;
    end

endmodule
